### hdl/assert_macros.svh
// Assertion macros shared by the plane point rotator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define PRR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("plane point rotator check failed");

// Clocked check that also holds during reset.
`define PRR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("plane point rotator check failed");

`endif

### hdl/prr_pkg.sv
// Types, constants and the arctangent table of the plane point rotator.
`timescale 1ns / 1ps

package prr_pkg;

   localparam int ANGLE_W    = 17;  // request angle, 1/128 degree
   localparam int WRAP_W     = ANGLE_W + 1;
   localparam int TURN_W     = 16;  // angle after the modulo, 0 .. 46079
   localparam int ANGLE_FRAC = 16;  // 1/128 degree -> 2^-23 degree
   localparam int ACC_W      = 32;  // residual angle accumulator
   localparam int SCALED_W   = 58;  // coordinate plus guard bits
   localparam int EXT_W      = 60;  // headroom for fold negate and CORDIC gain
   localparam int MAX_STAGES = 32;
   localparam int MUL_SPLIT  = 32;  // low partial product width
   localparam int GAIN_W     = 32;
   localparam int SUM_W      = EXT_W + 1;

   localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;  // 0.6072529350 * 2^32

   localparam logic signed [WRAP_W-1:0] WRAP_ZERO = 18'sd0;
   localparam logic signed [WRAP_W-1:0] WRAP_FULL = 18'sd46080;
   localparam logic signed [WRAP_W-1:0] WRAP_TWO  = 18'sd92160;

   localparam logic [TURN_W-1:0] TURN_QUARTER       = 16'd11520;
   localparam logic [TURN_W-1:0] TURN_THREE_QUARTER = 16'd34560;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN = 17'sd23040;
   localparam logic signed [ANGLE_W-1:0] FULL_TURN = 17'sd46080;

   typedef struct packed {
      logic signed [EXT_W-1:0] y;
      logic signed [EXT_W-1:0] z;
      logic signed [ACC_W-1:0] acc;
   } cordic_type;

   // atan(2^-i) in 2^-23 degree, rounded to nearest
   function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         0:  val = 32'sd377487360;
         1:  val = 32'sd222843801;
         2:  val = 32'sd117744544;
         3:  val = 32'sd59768969;
         4:  val = 32'sd30000467;
         5:  val = 32'sd15014858;
         6:  val = 32'sd7509261;
         7:  val = 32'sd3754860;
         8:  val = 32'sd1877459;
         9:  val = 32'sd938733;
         10: val = 32'sd469367;
         11: val = 32'sd234683;
         12: val = 32'sd117342;
         13: val = 32'sd58671;
         14: val = 32'sd29335;
         15: val = 32'sd14668;
         16: val = 32'sd7334;
         17: val = 32'sd3667;
         18: val = 32'sd1833;
         19: val = 32'sd917;
         20: val = 32'sd458;
         21: val = 32'sd229;
         22: val = 32'sd115;
         23: val = 32'sd57;
         24: val = 32'sd29;
         25: val = 32'sd14;
         26: val = 32'sd7;
         27: val = 32'sd4;
         28: val = 32'sd2;
         29: val = 32'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### hdl/plane_point_rotator.sv
// Top level of the plane point rotator: CORDIC rotation of a Y-Z point.
// Pipeline: NUM_STAGES + 6 register stages (26 at defaults), two in the fold and four in the finish.
// Throughput: one request per cycle unless a stalled result has filled the pipe; every stage is a
//   register with its own valid bit, so bubbles close up and a stalled result blocks only when full.
// Reset: synchronous, active high; clears every valid bit, payload is not reset.
`timescale 1ns / 1ps

module plane_point_rotator #(
   parameter  int COORD_WIDTH     = 32,
   parameter  int ROTATION_STAGES = 20,
   localparam int REQ_W = ((2 * COORD_WIDTH + prr_pkg::ANGLE_W + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // coord_y, coord_z, angle_deg, zero fill
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // rotated_y, rotated_z, zero fill
);
   import prr_pkg::*;

   // the stage count is capped at 32; table entries beyond 29 are zero
   localparam int NUM_STAGES = (ROTATION_STAGES < MAX_STAGES) ? ROTATION_STAGES : MAX_STAGES;

   logic signed [COORD_WIDTH-1:0] coord_y, coord_z;
   logic signed [ANGLE_W-1:0]     angle_deg;
   logic signed [COORD_WIDTH-1:0] rotated_y, rotated_z;

   // CORDIC chain: slot 0 is the fold output, slot NUM_STAGES feeds the finish
   cordic_type chain_data  [NUM_STAGES+1];
   logic       chain_valid [NUM_STAGES+1];
   logic       chain_ready [NUM_STAGES+1];

   // unpack the request
   assign coord_y   = req_tdata[COORD_WIDTH-1:0];
   assign coord_z   = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign angle_deg = req_tdata[2*COORD_WIDTH+ANGLE_W-1:2*COORD_WIDTH];

   // wrap the angle to one turn, fold to +-90 degrees, scale up the point
   prr_fold #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coord_y   (coord_y),
      .coord_z   (coord_z),
      .angle_deg (angle_deg),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // one micro-rotation per register stage, shift i in stage i
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      prr_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // gain removal and saturation; its last stage is the output register
   prr_finish #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_STAGES]),
      .in_ready  (chain_ready[NUM_STAGES]),
      .in_data   (chain_data[NUM_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .rotated_y (rotated_y),
      .rotated_z (rotated_z)
   );

   // pack the result, zero filled to whole bytes
   assign rsp_tdata = RSP_W'({rotated_z, rotated_y});

endmodule

### hdl/prr_fold.sv
// Angle wrap, quadrant fold and coordinate scaling: two pipeline stages.
`timescale 1ns / 1ps

module prr_fold #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [COORD_WIDTH-1:0]         coord_y,
   input  logic signed [COORD_WIDTH-1:0]         coord_z,
   input  logic signed [prr_pkg::ANGLE_W-1:0]    angle_deg,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output prr_pkg::cordic_type                   out_data
);
   import prr_pkg::*;

   localparam int GUARD_BITS = SCALED_W - COORD_WIDTH;
   localparam int PAD_BITS   = EXT_W - SCALED_W;

   // stage A: angle modulo a full turn
   logic signed [WRAP_W-1:0]      ang_wide;
   logic signed [WRAP_W-1:0]      ang_mod;
   logic                          valid_a_ff;
   logic [TURN_W-1:0]             turn_a_ff, turn_a_in;
   logic signed [COORD_WIDTH-1:0] y_a_ff, z_a_ff;
   logic                          ready_a, ready_b;

   // stage B: fold into +-90 degrees
   logic signed [ANGLE_W-1:0]     turn_s;
   logic signed [ANGLE_W-1:0]     ang_fold;
   logic                          flip;
   logic signed [EXT_W-1:0]       y_scaled, z_scaled;
   logic                          valid_b_ff;
   cordic_type                    data_b_ff, data_b_in;

   assign ang_wide = {angle_deg[ANGLE_W-1], angle_deg};

   always_comb begin
      if (ang_wide < -WRAP_FULL) begin
         ang_mod = ang_wide + WRAP_TWO;
      end else if (ang_wide < WRAP_ZERO) begin
         ang_mod = ang_wide + WRAP_FULL;
      end else if (ang_wide < WRAP_FULL) begin
         ang_mod = ang_wide;
      end else begin
         ang_mod = ang_wide - WRAP_FULL;
      end
   end

   assign turn_a_in = ang_mod[TURN_W-1:0];
   assign ready_b   = !valid_b_ff || out_ready;
   assign ready_a   = !valid_a_ff || ready_b;
   assign in_ready  = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (ready_a) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         turn_a_ff <= turn_a_in;
         y_a_ff    <= coord_y;
         z_a_ff    <= coord_z;
      end
   end

   assign turn_s = {1'b0, turn_a_ff};

   always_comb begin
      if (turn_a_ff <= TURN_QUARTER) begin
         ang_fold = turn_s;
         flip     = 1'b0;
      end else if (turn_a_ff < TURN_THREE_QUARTER) begin
         ang_fold = turn_s - HALF_TURN;
         flip     = 1'b1;
      end else begin
         ang_fold = turn_s - FULL_TURN;
         flip     = 1'b0;
      end
   end

   assign y_scaled = {{PAD_BITS{y_a_ff[COORD_WIDTH-1]}}, y_a_ff, {GUARD_BITS{1'b0}}};
   assign z_scaled = {{PAD_BITS{z_a_ff[COORD_WIDTH-1]}}, z_a_ff, {GUARD_BITS{1'b0}}};

   always_comb begin
      data_b_in.y   = flip ? -y_scaled : y_scaled;
      data_b_in.z   = flip ? -z_scaled : z_scaled;
      // folded angle stays within a quarter turn, so its low bits hold it whole
      data_b_in.acc = {ang_fold[ACC_W-ANGLE_FRAC-1:0], {ANGLE_FRAC{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_b) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         data_b_ff <= data_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_data  = data_b_ff;

endmodule

### hdl/prr_cordic_stage.sv
// One registered CORDIC micro-rotation with a fixed shift.
`timescale 1ns / 1ps

module prr_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  prr_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output prr_pkg::cordic_type out_data
);
   import prr_pkg::*;

   localparam logic signed [ACC_W-1:0] ANGLE_STEP = atan_entry(SHIFT);

   logic signed [EXT_W-1:0] y_cur, z_cur, dy, dz;
   logic signed [ACC_W-1:0] acc_cur;
   logic                    valid_ff;
   cordic_type              data_ff, data_in;

   assign y_cur   = in_data.y;
   assign z_cur   = in_data.z;
   assign acc_cur = in_data.acc;
   assign dy      = y_cur >>> SHIFT;  // floor shift
   assign dz      = z_cur >>> SHIFT;

   always_comb begin
      if (!acc_cur[ACC_W-1]) begin
         data_in.y   = y_cur - dz;
         data_in.z   = z_cur + dy;
         data_in.acc = acc_cur - ANGLE_STEP;
      end else begin
         data_in.y   = y_cur + dz;
         data_in.z   = z_cur - dy;
         data_in.acc = acc_cur + ANGLE_STEP;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/prr_finish.sv
// Gain removal, rounding and saturation for both coordinates: four stages.
`timescale 1ns / 1ps

module prr_finish #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  prr_pkg::cordic_type           in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] rotated_y,
   output logic signed [COORD_WIDTH-1:0] rotated_z
);
   import prr_pkg::*;

   localparam int GUARD_BITS = SCALED_W - COORD_WIDTH;
   localparam int HI_W       = EXT_W - MUL_SPLIT;
   localparam int HI_PROD_W  = HI_W + GAIN_W;
   localparam int LO_PROD_W  = MUL_SPLIT + GAIN_W;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (GUARD_BITS - 1);
   localparam logic [SUM_W-1:0] SAT_LIMIT  = SUM_W'(1) << (COORD_WIDTH - 1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   logic signed [EXT_W-1:0]     lane_val [2];
   logic                        neg1_ff [2], neg2_ff [2], neg3_ff [2];
   logic [EXT_W-1:0]            mag1_ff [2], mag1_in [2];
   logic [HI_PROD_W-1:0]        prod_hi_ff [2], prod_hi_in [2];
   logic [LO_PROD_W-1:0]        prod_lo [2];
   logic [MUL_SPLIT-1:0]        lo_top_ff [2];
   logic [SUM_W-1:0]            sum_ff [2], sum_in [2];
   logic [SUM_W-1:0]            quot [2], clamped [2], negated [2];
   logic [COORD_WIDTH-1:0]      res_ff [2], res_in [2];

   assign lane_val[0] = in_data.y;
   assign lane_val[1] = in_data.z;

   // valid chain, a stage fills when it is empty or drains
   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
         if (r4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      // magnitude
      assign mag1_in[l] = lane_val[l][EXT_W-1] ? -lane_val[l] : lane_val[l];

      // split multiply by the inverse gain, low part keeps only its top half
      assign prod_hi_in[l] = mag1_ff[l][EXT_W-1:MUL_SPLIT] * INV_GAIN;
      assign prod_lo[l]    = mag1_ff[l][MUL_SPLIT-1:0] * INV_GAIN;

      assign sum_in[l] = SUM_W'(prod_hi_ff[l]) + SUM_W'(lo_top_ff[l]) + ROUND_HALF;

      // drop guard bits, clamp to range, restore sign
      assign quot[l] = sum_ff[l] >> GUARD_BITS;

      always_comb begin
         if (neg3_ff[l]) begin
            clamped[l] = (quot[l] > SAT_LIMIT) ? SAT_LIMIT : quot[l];
         end else begin
            clamped[l] = (quot[l] > SAT_LIMIT - SUM_W'(1)) ? SAT_LIMIT - SUM_W'(1) : quot[l];
         end
      end

      assign negated[l] = -clamped[l];
      assign res_in[l]  = neg3_ff[l] ? negated[l][COORD_WIDTH-1:0]
                                     : clamped[l][COORD_WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (r1) begin
            neg1_ff[l] <= lane_val[l][EXT_W-1];
            mag1_ff[l] <= mag1_in[l];
         end
         if (r2) begin
            neg2_ff[l]    <= neg1_ff[l];
            prod_hi_ff[l] <= prod_hi_in[l];
            lo_top_ff[l]  <= prod_lo[l][LO_PROD_W-1:MUL_SPLIT];
         end
         if (r3) begin
            neg3_ff[l] <= neg2_ff[l];
            sum_ff[l]  <= sum_in[l];
         end
         if (r4) begin
            res_ff[l] <= res_in[l];
         end
      end
   end

   assign out_valid = v4_ff;
   assign rotated_y = res_ff[0];
   assign rotated_z = res_ff[1];

endmodule

### hdl/prr_checker.sv
// Port-level checks for the plane point rotator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prr_checker #(
   parameter int REQ_W = 88,
   parameter int RSP_W = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // an offered request keeps its value until taken
   `PRR_ASSERT(a_req_hold, (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))

   // a held result keeps its value until taken
   `PRR_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

   // back pressure only comes from a full pipe behind a stalled output
   `PRR_ASSERT(a_req_ready, (rsp_tready || !rsp_tvalid) |-> req_tready)

   // nothing can reach the output straight after reset
   `PRR_ASSERT_ALWAYS(a_reset_drain, reset |=> !rsp_tvalid ##1 !rsp_tvalid ##1 !rsp_tvalid)

endmodule

bind plane_point_rotator prr_checker #(
   .REQ_W (REQ_W),
   .RSP_W (RSP_W)
) u_prr_checker (.*);
